// ----- design/sle_pkg.sv -----
// Shared types and codes for the sorted list engine.
`timescale 1ns / 1ps

package sle_pkg;

  // Field widths fixed by the item formats
  localparam int unsigned OP_W    = 3;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned COUNT_W = 5;

  // Operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
  localparam logic [OP_W-1:0] OP_FIND   = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
  localparam logic [OP_W-1:0] OP_SHOW   = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]           op;
    logic signed [VALUE_W-1:0] value;
  } req_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] element;
    logic                      found;
    logic [STAT_W-1:0]         status;
    logic [COUNT_W-1:0]        count_after;
    logic                      last;
  } rsp_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_READ,
    S_EVAL,
    S_PLACE
  } ctrl_state_t;

endpackage

// ----- design/sorted_list_engine.sv -----
// Insert, find and remove work one entry at a time, each with a read and an evaluation step.
// Show and clear emit one entry per read; an empty list or a full insert is answered from the start state.
// One item is worked at a time; the single read port of the entry store sets the pace.
// Results sit in an output register, so a new item is taken while one waits.
// Reset clears the entry count and the sequencer; stored words are left as they are.
`timescale 1ns / 1ps

module sorted_list_engine #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  sle_pkg::req_item_t  req,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output sle_pkg::rsp_item_t  rsp
);

  localparam int unsigned IW = $clog2(DEPTH);

  logic                          out_free;
  logic                          emit;
  sle_pkg::rsp_item_t            res;
  logic                          we;
  logic [IW-1:0]                 waddr;
  logic [sle_pkg::VALUE_W-1:0]   wdata;
  logic                          re;
  logic [IW-1:0]                 raddr;
  logic [sle_pkg::VALUE_W-1:0]   rdata;

  // Sequencer
  sle_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .out_free  (out_free),
    .emit      (emit),
    .res       (res),
    .we        (we),
    .waddr     (waddr),
    .wdata     (wdata),
    .re        (re),
    .raddr     (raddr),
    .rdata     (rdata)
  );

  // Entry store
  sle_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Result register
  sle_outreg u_outreg (
    .clk       (clk),
    .rst       (rst),
    .load      (emit),
    .item      (res),
    .free      (out_free),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

// ----- design/sle_mem.sv -----
// Entry store: single write port, single registered read port.
`timescale 1ns / 1ps

module sle_mem #(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned IW   = $clog2(DEPTH)
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [IW-1:0]                  waddr,
  input  logic [sle_pkg::VALUE_W-1:0]    wdata,
  input  logic                           re,
  input  logic [IW-1:0]                  raddr,
  output logic [sle_pkg::VALUE_W-1:0]    rdata
);

  logic [sle_pkg::VALUE_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/sle_outreg.sv -----
// Result register between the sequencer and the result channel.
`timescale 1ns / 1ps

module sle_outreg (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  sle_pkg::rsp_item_t  item,
  output logic                free,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output sle_pkg::rsp_item_t  rsp
);

  logic full;

  // Hold a result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (rsp_ready) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp <= item;
    end
  end

  assign free      = !full || rsp_ready;
  assign rsp_valid = full;

endmodule

// ----- design/sle_ctrl.sv -----
// Sequencer: scans, shifts and emits over the entry store.
`timescale 1ns / 1ps

module sle_ctrl #(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned IW   = $clog2(DEPTH),
  localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_ready,
  input  sle_pkg::req_item_t             req,
  input  logic                           out_free,
  output logic                           emit,
  output sle_pkg::rsp_item_t             res,
  output logic                           we,
  output logic [IW-1:0]                  waddr,
  output logic [sle_pkg::VALUE_W-1:0]    wdata,
  output logic                           re,
  output logic [IW-1:0]                  raddr,
  input  logic [sle_pkg::VALUE_W-1:0]    rdata
);

  localparam int unsigned CNT_OUT_W = sle_pkg::COUNT_W;
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  sle_pkg::ctrl_state_t state, state_next;

  logic [sle_pkg::OP_W-1:0]           op_r, op_r_next;
  logic signed [sle_pkg::VALUE_W-1:0] val_r, val_r_next;
  logic [CW-1:0]                      n, n_next;
  logic [CW-1:0]                      idx, idx_next;
  logic                               hit, hit_next;

  logic [CW-1:0]                      n_m1, idx_m1, idx_p1;
  logic                               last_scan;
  logic                               hit_now;
  logic signed [sle_pkg::VALUE_W-1:0] d;

  assign n_m1      = n - 1'b1;
  assign idx_m1    = idx - 1'b1;
  assign idx_p1    = idx + 1'b1;
  assign last_scan = (idx == n_m1);
  assign d         = $signed(rdata);
  assign hit_now   = hit || (d == val_r);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sle_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      n   <= '0;
      idx <= '0;
      hit <= 1'b0;
    end else begin
      n   <= n_next;
      idx <= idx_next;
      hit <= hit_next;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_r_next;
    val_r <= val_r_next;
  end

  // Next state, store accesses and results
  always_comb begin
    state_next = state;
    op_r_next  = op_r;
    val_r_next = val_r;
    n_next     = n;
    idx_next   = idx;
    hit_next   = hit;
    req_ready  = 1'b0;
    emit       = 1'b0;
    res        = '0;
    we         = 1'b0;
    waddr      = idx[IW-1:0];
    wdata      = val_r;
    re         = 1'b0;
    raddr      = idx[IW-1:0];

    case (state)
      sle_pkg::S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          op_r_next  = req.op;
          val_r_next = req.value;
          state_next = sle_pkg::S_START;
        end
      end

      sle_pkg::S_START: begin
        hit_next = 1'b0;
        idx_next = '0;
        res.last = 1'b1;
        case (op_r)
          sle_pkg::OP_INSERT: begin
            if (n == FULL_CNT) begin
              res.status      = sle_pkg::ST_FULL;
              res.count_after = CNT_OUT_W'(n);
              if (out_free) begin
                emit       = 1'b1;
                state_next = sle_pkg::S_IDLE;
              end
            end else if (n == '0) begin
              state_next = sle_pkg::S_PLACE;
            end else begin
              idx_next   = n;
              state_next = sle_pkg::S_READ;
            end
          end
          sle_pkg::OP_FIND, sle_pkg::OP_REMOVE, sle_pkg::OP_SHOW, sle_pkg::OP_CLEAR: begin
            if (n == '0) begin
              res.status = sle_pkg::ST_EMPTY;
              if (out_free) begin
                emit       = 1'b1;
                state_next = sle_pkg::S_IDLE;
              end
            end else begin
              state_next = sle_pkg::S_READ;
            end
          end
          default: begin
            state_next = sle_pkg::S_IDLE;
          end
        endcase
      end

      sle_pkg::S_READ: begin
        re         = 1'b1;
        raddr      = (op_r == sle_pkg::OP_INSERT) ? idx_m1[IW-1:0] : idx[IW-1:0];
        state_next = sle_pkg::S_EVAL;
      end

      sle_pkg::S_EVAL: begin
        case (op_r)
          // Walk down from the top, shifting up every entry not below the value
          sle_pkg::OP_INSERT: begin
            if (d < val_r) begin
              state_next = sle_pkg::S_PLACE;
            end else begin
              we         = 1'b1;
              waddr      = idx[IW-1:0];
              wdata      = rdata;
              idx_next   = idx_m1;
              state_next = (idx_m1 == '0) ? sle_pkg::S_PLACE : sle_pkg::S_READ;
            end
          end

          // Stop at the first match or at the end of the list
          sle_pkg::OP_FIND: begin
            res.last        = 1'b1;
            res.count_after = CNT_OUT_W'(n);
            if (d == val_r) begin
              res.found  = 1'b1;
              res.status = sle_pkg::ST_OK;
              if (out_free) begin
                emit       = 1'b1;
                state_next = sle_pkg::S_IDLE;
              end
            end else if (last_scan) begin
              res.status = sle_pkg::ST_NOTFOUND;
              if (out_free) begin
                emit       = 1'b1;
                state_next = sle_pkg::S_IDLE;
              end
            end else begin
              idx_next   = idx_p1;
              state_next = sle_pkg::S_READ;
            end
          end

          // Once the first match is seen, move every later entry down by one
          sle_pkg::OP_REMOVE: begin
            res.last = 1'b1;
            if (hit_now) begin
              res.status      = sle_pkg::ST_OK;
              res.count_after = CNT_OUT_W'(n_m1);
            end else begin
              res.status      = sle_pkg::ST_NOTFOUND;
              res.count_after = CNT_OUT_W'(n);
            end
            waddr = idx_m1[IW-1:0];
            wdata = rdata;
            if (!last_scan) begin
              we         = hit;
              hit_next   = hit_now;
              idx_next   = idx_p1;
              state_next = sle_pkg::S_READ;
            end else if (out_free) begin
              we         = hit;
              emit       = 1'b1;
              n_next     = hit_now ? n_m1 : n;
              state_next = sle_pkg::S_IDLE;
            end
          end

          // Emit one entry per read, draining the count on clear
          sle_pkg::OP_SHOW, sle_pkg::OP_CLEAR: begin
            res.element     = d;
            res.status      = sle_pkg::ST_OK;
            res.last        = last_scan;
            res.count_after = (op_r == sle_pkg::OP_CLEAR) ?
                              CNT_OUT_W'(n_m1 - idx) : CNT_OUT_W'(n);
            if (out_free) begin
              emit = 1'b1;
              if (last_scan) begin
                if (op_r == sle_pkg::OP_CLEAR) begin
                  n_next = '0;
                end
                state_next = sle_pkg::S_IDLE;
              end else begin
                idx_next   = idx_p1;
                state_next = sle_pkg::S_READ;
              end
            end
          end

          default: begin
            state_next = sle_pkg::S_IDLE;
          end
        endcase
      end

      // Drop the new value into the gap
      sle_pkg::S_PLACE: begin
        res.status      = sle_pkg::ST_OK;
        res.last        = 1'b1;
        res.count_after = CNT_OUT_W'(n + 1'b1);
        if (out_free) begin
          we         = 1'b1;
          emit       = 1'b1;
          n_next     = n + 1'b1;
          state_next = sle_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = sle_pkg::S_IDLE;
      end
    endcase
  end

endmodule
